>>> src/lwkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwkd_pkg: shared constants, types and helpers
// Widths of the key table, counters and stream buses, plus the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lwkd_pkg;

    // table and field sizes
    localparam int MAX_K     = 16;
    localparam int KEY_BITS  = 32;
    localparam int CNT_BITS  = 32;
    localparam int K_BITS    = 5;

    localparam int IDX_W     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int USED_W    = $clog2(MAX_K + 1);

    // oldest-entry search: entries folded into groups in the scan cycle, groups folded at evict
    localparam int GRP_SIZE  = 4;
    localparam int NUM_GRP   = (MAX_K + GRP_SIZE - 1) / GRP_SIZE;

    // stream bus widths
    localparam int S_TDATA_W = ((KEY_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 2 * CNT_BITS;

    typedef logic [CNT_BITS-1:0] cnt_t;
    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [USED_W-1:0]   used_t;
    typedef logic [K_BITS-1:0]   kval_t;

    localparam cnt_t CNT_MAX = '1;

    // eviction candidate: a valid entry with its last position
    typedef struct packed {
        logic vld;
        idx_t idx;
        cnt_t pos;
    } cand_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic evict;
        logic commit;
    } lwkd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_evict;
        logic out_free;
    } lwkd_sts_t;

    // keep a unless b is valid and strictly older; ties keep the lower index
    function automatic cand_t cand_pick(input cand_t a, input cand_t b);
        cand_t r;
        r = a;
        if (b.vld && (!a.vld || (b.pos < a.pos)))
        begin
            r = b;
        end
        return r;
    endfunction

endpackage

>>> src/lwkd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwkd_ctrl: sequencing state machine
// Accepts one request, runs the table scan, repeats evictions while the
// table is at its limit, then commits the result into the output register.
// ----------------------------------------------------------------------------
module lwkd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lwkd_pkg::lwkd_sts_t sts,
    output lwkd_pkg::lwkd_cmd_t cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = sts.need_evict ? ST_EVICT : ST_COMMIT;
            end
            ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                ready_next = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

>>> src/lwkd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwkd_datapath: key table, window counters and output register
// Holds up to MAX_K keys with their last positions, finds hits, free slots
// and the oldest entry, and forms window and best lengths.
// ----------------------------------------------------------------------------
module lwkd_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  lwkd_pkg::kval_t                cfg_wdata,
    input  logic [lwkd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lwkd_pkg::M_TDATA_W-1:0] m_tdata,
    input  lwkd_pkg::lwkd_cmd_t            cmd,
    output lwkd_pkg::lwkd_sts_t            sts
);

    // configuration and sequence state
    lwkd_pkg::kval_t                k_reg;
    logic [lwkd_pkg::MAX_K-1:0]     valid_reg;
    lwkd_pkg::cnt_t                 pos_reg;
    lwkd_pkg::cnt_t                 wstart_reg;
    lwkd_pkg::cnt_t                 best_reg;
    logic                           m_tvalid_reg;

    // table storage and per-request payload
    lwkd_pkg::key_t                 entry_key [lwkd_pkg::MAX_K];
    lwkd_pkg::cnt_t                 entry_pos [lwkd_pkg::MAX_K];
    lwkd_pkg::key_t                 key_reg;
    logic                           hit_reg;
    lwkd_pkg::idx_t                 hit_idx_reg;
    lwkd_pkg::idx_t                 free_idx_reg;
    lwkd_pkg::cand_t                grp_reg [lwkd_pkg::NUM_GRP];
    logic [lwkd_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // scan results
    logic                           hit;
    lwkd_pkg::idx_t                 hit_idx;
    lwkd_pkg::idx_t                 free_idx;
    lwkd_pkg::used_t                used;
    lwkd_pkg::used_t                k_eff;
    lwkd_pkg::cand_t                grp_now [lwkd_pkg::NUM_GRP];
    lwkd_pkg::cand_t                oldest;
    lwkd_pkg::cnt_t                 evict_start;

    // commit results
    logic [lwkd_pkg::CNT_BITS:0]    pos_plus;
    logic [lwkd_pkg::CNT_BITS:0]    len_wide;
    lwkd_pkg::cnt_t                 len;
    lwkd_pkg::cnt_t                 best_next;
    lwkd_pkg::cnt_t                 pos_inc;

    // k clamped to 1..MAX_K
    always_comb
    begin
        if (k_reg == '0)
        begin
            k_eff = lwkd_pkg::used_t'(1);
        end
        else if (int'(k_reg) > lwkd_pkg::MAX_K)
        begin
            k_eff = lwkd_pkg::used_t'(lwkd_pkg::MAX_K);
        end
        else
        begin
            k_eff = lwkd_pkg::used_t'(k_reg);
        end
    end

    // parallel compare, occupancy count, lowest free slot
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        used     = '0;
        for (int i = lwkd_pkg::MAX_K - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (entry_key[i] == key_reg))
            begin
                hit     = 1'b1;
                hit_idx = lwkd_pkg::idx_t'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = lwkd_pkg::idx_t'(i);
            end
            used = used + lwkd_pkg::used_t'(valid_reg[i]);
        end
    end

    // first level of the oldest search: one winner per group
    always_comb
    begin
        lwkd_pkg::cand_t c;
        lwkd_pkg::cand_t e;
        int              n;
        for (int g = 0; g < lwkd_pkg::NUM_GRP; g++)
        begin
            c = '0;
            for (int j = 0; j < lwkd_pkg::GRP_SIZE; j++)
            begin
                n = g * lwkd_pkg::GRP_SIZE + j;
                if (n < lwkd_pkg::MAX_K)
                begin
                    e.vld = valid_reg[n];
                    e.idx = lwkd_pkg::idx_t'(n);
                    e.pos = entry_pos[n];
                    c     = lwkd_pkg::cand_pick(c, e);
                end
            end
            grp_now[g] = c;
        end
    end

    // second level over the registered group winners
    always_comb
    begin
        oldest = '0;
        for (int g = 0; g < lwkd_pkg::NUM_GRP; g++)
        begin
            oldest = lwkd_pkg::cand_pick(oldest, grp_reg[g]);
        end
        evict_start = (oldest.pos == lwkd_pkg::CNT_MAX) ? lwkd_pkg::CNT_MAX
                                                         : oldest.pos + 1'b1;
    end

    // window length, best length, saturating position
    always_comb
    begin
        pos_plus = {1'b0, pos_reg} + 1'b1;
        if (pos_plus >= {1'b0, wstart_reg})
        begin
            len_wide = pos_plus - {1'b0, wstart_reg};
        end
        else
        begin
            len_wide = '0;
        end
        len       = len_wide[lwkd_pkg::CNT_BITS] ? lwkd_pkg::CNT_MAX
                                                 : len_wide[lwkd_pkg::CNT_BITS-1:0];
        best_next = (len > best_reg) ? len : best_reg;
        pos_inc   = (pos_reg == lwkd_pkg::CNT_MAX) ? pos_reg : pos_reg + 1'b1;
    end

    // status to controller
    assign sts.need_evict = !hit && (used >= k_eff);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // control state: config, valid bits, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= lwkd_pkg::kval_t'(1);
            valid_reg    <= '0;
            pos_reg      <= '0;
            wstart_reg   <= '0;
            best_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                k_reg <= cfg_wdata;
            end
            if (cmd.load && s_tuser)
            begin
                valid_reg  <= '0;
                pos_reg    <= '0;
                wstart_reg <= '0;
                best_reg   <= '0;
            end
            if (cmd.evict)
            begin
                valid_reg[oldest.idx] <= 1'b0;
                wstart_reg            <= evict_start;
            end
            if (cmd.commit)
            begin
                if (!hit_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                best_reg     <= best_next;
                pos_reg      <= pos_inc;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: table contents, scan results, output data
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= s_tdata[lwkd_pkg::KEY_BITS-1:0];
        end
        if (cmd.scan)
        begin
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            free_idx_reg <= free_idx;
            grp_reg      <= grp_now;
        end
        if (cmd.commit)
        begin
            if (hit_reg)
            begin
                entry_pos[hit_idx_reg] <= pos_reg;
            end
            else
            begin
                entry_key[free_idx_reg] <= key_reg;
                entry_pos[free_idx_reg] <= pos_reg;
            end
            m_tdata_reg <= {best_next, len};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> src/longest_window_k_distinct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_window_k_distinct_core: longest run with at most k distinct keys
// Streams keys in, returns the current window length and best length for
// each request; the first flag starts a new sequence.
// ----------------------------------------------------------------------------
// Flow: a taken request runs a scan, then commits into the registered result;
//   each eviction adds an evict and another scan (repeated once per removed key).
// A new request is taken only after the previous one commits, and commit waits
//   while the output holds a result that has not yet been taken.
// Reset: clears the table valid bits, position, window start and best length,
//   and sets max_distinct to 1; no clearing pass is needed.
module longest_window_k_distinct_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: max_distinct
    input  logic                           cfg_we,
    input  lwkd_pkg::kval_t                cfg_wdata,
    // input requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lwkd_pkg::S_TDATA_W-1:0] s_tdata,   // key
    input  logic                           s_tuser,   // first
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lwkd_pkg::M_TDATA_W-1:0] m_tdata    // best_length (upper), window_length (lower)
);

    lwkd_pkg::lwkd_cmd_t cmd;
    lwkd_pkg::lwkd_sts_t sts;

    lwkd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lwkd_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> src/lwkd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwkd_checker: port-level checks
// Watches the stream ports of the core and flags impossible results or
// sequencing slips.
// ----------------------------------------------------------------------------
module lwkd_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lwkd_pkg::M_TDATA_W-1:0] m_tdata
);

    // best length never trails the current window
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[lwkd_pkg::M_TDATA_W-1:lwkd_pkg::CNT_BITS]
                      >= m_tdata[lwkd_pkg::CNT_BITS-1:0]))
        else $error("best_length below window_length");

    // every window holds at least the current key
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[lwkd_pkg::CNT_BITS-1:0] != '0))
        else $error("empty window reported");

    // one request in flight: ready drops after a take
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

endmodule

bind longest_window_k_distinct_core lwkd_checker u_lwkd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
